[design/itp_pkg.sv]
// Shared types, constants and the precedence table of the infix-to-postfix converter.
package itp_pkg;

  // Stack geometry
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);

  // Field widths
  localparam int unsigned OP_W   = 3;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned REF_W  = 16;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned ERR_W  = 2;
  localparam int unsigned PREC_W = 3;
  localparam int unsigned ENTRY_W = KIND_W + CODE_W;

  // Input token kinds
  localparam logic [OP_W-1:0] OP_OPD = 3'd0;
  localparam logic [OP_W-1:0] OP_OPR = 3'd1;
  localparam logic [OP_W-1:0] OP_FCT = 3'd2;
  localparam logic [OP_W-1:0] OP_LP  = 3'd3;
  localparam logic [OP_W-1:0] OP_RP  = 3'd4;
  localparam logic [OP_W-1:0] OP_END = 3'd5;

  // Kinds of stack entries
  localparam logic [KIND_W-1:0] SK_OPR = 2'd1;
  localparam logic [KIND_W-1:0] SK_FCT = 2'd2;
  localparam logic [KIND_W-1:0] SK_LP  = 2'd3;

  // Kinds of emitted results
  localparam logic [KIND_W-1:0] RK_NONE = 2'd0;
  localparam logic [KIND_W-1:0] RK_OPD  = 2'd1;
  localparam logic [KIND_W-1:0] RK_OPR  = 2'd2;
  localparam logic [KIND_W-1:0] RK_FCT  = 2'd3;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_PAREN = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVF   = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             load;      // capture the input token
    logic             emit_top;  // emit the top stack entry as a result
    logic             emit_opd;  // emit the captured operand as a result
    logic             pop;       // drop the top stack entry
    logic             push;      // push the captured token
    logic             finish;    // close the item: last result with error code
    logic [ERR_W-1:0] err;       // error code used with finish
  } itp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [KIND_W-1:0] top_kind;
    logic [PREC_W-1:0] top_prec;
    logic [OP_W-1:0]   tok_op;
    logic [PREC_W-1:0] tok_prec;
    logic              out_free;
  } itp_stat_t;

  // Operator precedence; unknown codes rank lowest.
  function automatic logic [PREC_W-1:0] prec_of(input logic [CODE_W-1:0] code);
    logic [PREC_W-1:0] p;
    unique case (code) inside
      [4'd0:4'd6]:  p = 3'd3;
      4'd7, 4'd8:   p = 3'd4;
      4'd9, 4'd10:  p = 3'd5;
      4'd11:        p = 3'd2;
      4'd12:        p = 3'd1;
      default:      p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

[design/itp_ctrl.sv]
// Controller state machine of the infix-to-postfix converter.
module itp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  itp_pkg::itp_stat_t stat_i,
  output itp_pkg::itp_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WORK = 2'd1;
  localparam logic [1:0] ST_PARB = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]               state_q, state_d;
  logic [itp_pkg::ERR_W-1:0] err_q, err_d;
  logic                     lp_err_q, lp_err_d;
  logic                     opr_pop;

  assign s_axis_tready = (state_q == ST_IDLE);

  // Operator pops a function, or an operator of greater or equal precedence.
  assign opr_pop = !stat_i.empty &&
                   ((stat_i.top_kind == itp_pkg::SK_FCT) ||
                    ((stat_i.top_kind == itp_pkg::SK_OPR) &&
                     (stat_i.tok_prec <= stat_i.top_prec)));

  // Next state and commands; work only advances while the output can move.
  always_comb begin
    state_d  = state_q;
    err_d    = err_q;
    lp_err_d = lp_err_q;
    cmd_o    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          lp_err_d   = 1'b0;
          state_d    = ST_WORK;
        end
      end
      ST_WORK: begin
        if (stat_i.out_free) begin
          case (stat_i.tok_op) inside
            itp_pkg::OP_OPD: begin
              cmd_o.emit_opd = 1'b1;
              err_d          = itp_pkg::ERR_NONE;
              state_d        = ST_FIN;
            end
            itp_pkg::OP_OPR: begin
              if (opr_pop) begin
                cmd_o.emit_top = 1'b1;
                cmd_o.pop      = 1'b1;
              end else begin
                cmd_o.push   = !stat_i.full;
                cmd_o.finish = 1'b1;
                cmd_o.err    = stat_i.full ? itp_pkg::ERR_OVF : itp_pkg::ERR_NONE;
                state_d      = ST_IDLE;
              end
            end
            itp_pkg::OP_FCT, itp_pkg::OP_LP: begin
              cmd_o.push   = !stat_i.full;
              cmd_o.finish = 1'b1;
              cmd_o.err    = stat_i.full ? itp_pkg::ERR_OVF : itp_pkg::ERR_NONE;
              state_d      = ST_IDLE;
            end
            itp_pkg::OP_RP: begin
              if (stat_i.empty) begin
                cmd_o.finish = 1'b1;
                cmd_o.err    = itp_pkg::ERR_PAREN;
                state_d      = ST_IDLE;
              end else if (stat_i.top_kind != itp_pkg::SK_LP) begin
                cmd_o.emit_top = 1'b1;
                cmd_o.pop      = 1'b1;
              end else begin
                cmd_o.pop = 1'b1;
                state_d   = ST_PARB;
              end
            end
            itp_pkg::OP_END: begin
              if (stat_i.empty) begin
                cmd_o.finish = 1'b1;
                cmd_o.err    = lp_err_q ? itp_pkg::ERR_PAREN : itp_pkg::ERR_NONE;
                state_d      = ST_IDLE;
              end else if (stat_i.top_kind == itp_pkg::SK_LP) begin
                cmd_o.pop = 1'b1;
                lp_err_d  = 1'b1;
              end else begin
                cmd_o.emit_top = 1'b1;
                cmd_o.pop      = 1'b1;
              end
            end
            default: begin
              cmd_o.finish = 1'b1;
              cmd_o.err    = itp_pkg::ERR_NONE;
              state_d      = ST_IDLE;
            end
          endcase
        end
      end
      ST_PARB: begin
        // After a matched parenthesis, a function on top goes out with it.
        if (stat_i.out_free) begin
          if (!stat_i.empty && (stat_i.top_kind == itp_pkg::SK_FCT)) begin
            cmd_o.emit_top = 1'b1;
            cmd_o.pop      = 1'b1;
            err_d          = itp_pkg::ERR_NONE;
            state_d        = ST_FIN;
          end else begin
            cmd_o.finish = 1'b1;
            cmd_o.err    = itp_pkg::ERR_NONE;
            state_d      = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.err    = err_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      err_q    <= itp_pkg::ERR_NONE;
      lp_err_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      err_q    <= err_d;
      lp_err_q <= lp_err_d;
    end
  end

endmodule

[design/itp_datapath.sv]
// Datapath of the infix-to-postfix converter: token register, operator stack and result registers.
module itp_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          s_axis_tuser,   // op
  input  logic [23:0]         s_axis_tdata,   // operator_code[3:0], operand_ref[19:4], zero pad
  input  itp_pkg::itp_cmd_t   cmd_i,
  output itp_pkg::itp_stat_t  stat_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [1:0]          m_axis_tuser,   // out_kind
  output logic [23:0]         m_axis_tdata,   // out_operator[3:0], out_operand[19:4],
                                              // error_code[21:20], zero pad
  output logic                m_axis_tlast    // last
);

  localparam int unsigned DEPTH = itp_pkg::STACK_DEPTH;

  // Captured token
  logic [itp_pkg::OP_W-1:0]   tok_op_q;
  logic [itp_pkg::CODE_W-1:0] tok_code_q;
  logic [itp_pkg::REF_W-1:0]  tok_ref_q;

  // Operator stack
  logic [itp_pkg::ENTRY_W-1:0] stack_q [DEPTH];
  logic [itp_pkg::SP_W-1:0]    sp_q, sp_d;
  logic [itp_pkg::IDX_W-1:0]   top_idx;
  logic [itp_pkg::ENTRY_W-1:0] top_entry;
  logic [itp_pkg::ENTRY_W-1:0] push_entry;

  // Pending result, held back until it is known whether it is the last one
  logic                        pend_vld_q;
  logic [itp_pkg::KIND_W-1:0]  pend_kind_q;
  logic [itp_pkg::CODE_W-1:0]  pend_opr_q;
  logic [itp_pkg::REF_W-1:0]   pend_opd_q;

  // Output register
  logic                        out_vld_q;
  logic [itp_pkg::KIND_W-1:0]  out_kind_q;
  logic [itp_pkg::CODE_W-1:0]  out_opr_q;
  logic [itp_pkg::REF_W-1:0]   out_opd_q;
  logic [itp_pkg::ERR_W-1:0]   out_err_q;
  logic                        out_last_q;

  // New result made from the stack top or the captured operand
  logic [itp_pkg::KIND_W-1:0]  new_kind;
  logic [itp_pkg::CODE_W-1:0]  new_opr;
  logic [itp_pkg::REF_W-1:0]   new_opd;
  logic                        emit;
  logic                        out_free;

  assign top_idx   = sp_q[itp_pkg::IDX_W-1:0] - 1'b1;
  assign top_entry = stack_q[top_idx];
  assign out_free  = !out_vld_q || m_axis_tready;
  assign emit      = cmd_i.emit_top || cmd_i.emit_opd;

  // Entry pushed for the captured token
  always_comb begin
    case (tok_op_q)
      itp_pkg::OP_OPR: push_entry = {itp_pkg::SK_OPR, tok_code_q};
      itp_pkg::OP_FCT: push_entry = {itp_pkg::SK_FCT, {itp_pkg::CODE_W{1'b0}}};
      default:         push_entry = {itp_pkg::SK_LP, {itp_pkg::CODE_W{1'b0}}};
    endcase
  end

  // Result built from the stack top or from the operand
  always_comb begin
    if (cmd_i.emit_opd) begin
      new_kind = itp_pkg::RK_OPD;
      new_opr  = '0;
      new_opd  = tok_ref_q;
    end else if (top_entry[itp_pkg::ENTRY_W-1:itp_pkg::CODE_W] == itp_pkg::SK_FCT) begin
      new_kind = itp_pkg::RK_FCT;
      new_opr  = '0;
      new_opd  = '0;
    end else begin
      new_kind = itp_pkg::RK_OPR;
      new_opr  = top_entry[itp_pkg::CODE_W-1:0];
      new_opd  = '0;
    end
  end

  // Status for the controller
  assign stat_o.empty    = (sp_q == '0);
  assign stat_o.full     = (sp_q == itp_pkg::SP_W'(DEPTH));
  assign stat_o.top_kind = top_entry[itp_pkg::ENTRY_W-1:itp_pkg::CODE_W];
  assign stat_o.top_prec = itp_pkg::prec_of(top_entry[itp_pkg::CODE_W-1:0]);
  assign stat_o.tok_op   = tok_op_q;
  assign stat_o.tok_prec = itp_pkg::prec_of(tok_code_q);
  assign stat_o.out_free = out_free;

  // Token capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tok_op_q   <= s_axis_tuser;
      tok_code_q <= s_axis_tdata[3:0];
      tok_ref_q  <= s_axis_tdata[19:4];
    end
  end

  // Stack storage; entries above the pointer are never read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_q[sp_q[itp_pkg::IDX_W-1:0]] <= push_entry;
    end
  end

  // Stack pointer
  always_comb begin
    sp_d = sp_q;
    if (cmd_i.push) begin
      sp_d = sp_q + 1'b1;
    end else if (cmd_i.pop) begin
      sp_d = sp_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  // Pending and output valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (emit) begin
        pend_vld_q <= 1'b1;
        if (pend_vld_q) begin
          out_vld_q <= 1'b1;
        end else if (m_axis_tready) begin
          out_vld_q <= 1'b0;
        end
      end else if (cmd_i.finish) begin
        pend_vld_q <= 1'b0;
        out_vld_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Pending and output payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      pend_kind_q <= new_kind;
      pend_opr_q  <= new_opr;
      pend_opd_q  <= new_opd;
      if (pend_vld_q) begin
        out_kind_q <= pend_kind_q;
        out_opr_q  <= pend_opr_q;
        out_opd_q  <= pend_opd_q;
        out_err_q  <= itp_pkg::ERR_NONE;
        out_last_q <= 1'b0;
      end
    end else if (cmd_i.finish) begin
      out_kind_q <= pend_vld_q ? pend_kind_q : itp_pkg::RK_NONE;
      out_opr_q  <= pend_vld_q ? pend_opr_q : '0;
      out_opd_q  <= pend_vld_q ? pend_opd_q : '0;
      out_err_q  <= cmd_i.err;
      out_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {2'b00, out_err_q, out_opd_q, out_opr_q};
  assign m_axis_tlast  = out_last_q;

  // The pointer never leaves the stack.
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= itp_pkg::SP_W'(DEPTH))
    else $error("stack pointer beyond depth");

  // No push onto a full stack and no pop from an empty one.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push |-> !stat_o.full) and (cmd_i.pop |-> !stat_o.empty))
    else $error("stack push on full or pop on empty");

  // A result that moves out must never overwrite one still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish || (emit && pend_vld_q)) |-> out_free)
    else $error("output register overwritten");

  // Emitting and closing an item never coincide.
  a_emit_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit && cmd_i.finish))
    else $error("emit and finish in the same cycle");

endmodule

[design/infix_to_postfix_converter_top.sv]
// Each item is taken in the idle state; the controller then emits the popped operators and functions
// (or the operand) and closes the item with a last result that carries the error code.
// Throughput: one item at a time; the rate is set by the stack pop loop, one entry per cycle,
// and by the output stage when the consumer stalls.
// Reset (asynchronous, active low) empties the stack and clears all valid flags; stack
// contents are left undefined.
module infix_to_postfix_converter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,   // op
  input  logic [23:0] s_axis_tdata,   // operator_code[3:0], operand_ref[19:4], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [1:0]  m_axis_tuser,   // out_kind
  output logic [23:0] m_axis_tdata,   // out_operator[3:0], out_operand[19:4],
                                      // error_code[21:20], zero pad
  output logic        m_axis_tlast    // last
);

  itp_pkg::itp_cmd_t  cmd;
  itp_pkg::itp_stat_t stat;

  // Sequencer
  itp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // Stack and result path
  itp_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
